FILE: rtl/brbf_pkg.sv
package brbf_pkg;

    localparam int SIZE_W = 9;
    localparam int IDX_W  = 9;
    localparam int DIV_W  = 10;
    localparam int STEP_W = $clog2(DIV_W);

    localparam logic [2:0] FUNC_PUT      = 3'd0;
    localparam logic [2:0] FUNC_GET      = 3'd1;
    localparam logic [2:0] FUNC_FLUSH    = 3'd2;
    localparam logic [2:0] FUNC_ADV_TAIL = 3'd3;
    localparam logic [2:0] FUNC_SET_HEAD = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] data;
        logic [7:0] amount;
    } t_in_item;

    typedef struct packed {
        logic       ok;
        logic [7:0] read_data;
        logic [7:0] fill_count;
        logic [7:0] free_slots;
        logic       not_empty;
        logic [7:0] count_to_end;
        logic [7:0] tail_index;
    } t_out_item;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [SIZE_W-1:0] divisor;
    } t_mod_req;

    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] rem;
    } t_mod_rsp;

endpackage

FILE: rtl/brbf_mem.sv
module brbf_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/brbf_mod.sv
module brbf_mod (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  brbf_pkg::t_mod_req i_req,
    output brbf_pkg::t_mod_rsp o_rsp
);

    logic                           r_busy, n_busy;
    logic                           r_done, n_done;
    logic [brbf_pkg::STEP_W-1:0]    r_step, n_step;
    logic [brbf_pkg::IDX_W-1:0]     r_rem, n_rem;
    logic [brbf_pkg::DIV_W-1:0]     r_dvd, n_dvd;
    logic [brbf_pkg::SIZE_W-1:0]    r_dvs, n_dvs;
    logic [brbf_pkg::IDX_W:0]       trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        n_dvs  = r_dvs;
        trial  = {r_rem, r_dvd[brbf_pkg::DIV_W-1]};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_rem  = '0;
            n_dvd  = i_req.dividend;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            // one restoring remainder step per cycle
            if (trial >= (brbf_pkg::IDX_W+1)'(r_dvs)) begin
                n_rem = brbf_pkg::IDX_W'(trial - (brbf_pkg::IDX_W+1)'(r_dvs));
            end else begin
                n_rem = brbf_pkg::IDX_W'(trial);
            end
            n_dvd  = {r_dvd[brbf_pkg::DIV_W-2:0], 1'b0};
            n_step = brbf_pkg::STEP_W'(r_step + 1'b1);
            if (r_step == brbf_pkg::STEP_W'(brbf_pkg::DIV_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

FILE: rtl/byte_ring_buffer_fifo_core.sv
// byte fifo on a circular store, one slot always kept free
// input channel: i_in_valid / o_in_stall carry one transaction with func, data, amount
// output channel: o_out_valid / i_out_stall carry one result transaction per input
// config: i_cfg_we with i_cfg_wdata sets the slot count, clamped to 2..DEPTH,
//   and empties the fifo; write only while no transaction is in flight
// put, get, flush and unused codes take 2 cycles per transaction:
//   one cycle for the memory access, one to form the result
// advance tail and set head take 13 cycles: the modulo by the size runs
//   through a bit-serial remainder unit at one dividend bit per cycle
// one transaction is in flight at a time; the next is taken once its result
//   sits in the output register
// the result register holds while i_out_stall is high; a new result waits
//   in its final state until the register frees up
// reset empties the fifo and sets the size to 256 clamped to DEPTH;
//   storage content is not cleared
module byte_ring_buffer_fifo_core #(
    parameter int DEPTH = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  brbf_pkg::t_in_item          i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output brbf_pkg::t_out_item         o_out,
    input  logic                        i_cfg_we,
    input  logic [brbf_pkg::SIZE_W-1:0] i_cfg_wdata
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [brbf_pkg::SIZE_W-1:0] SizeRst =
        brbf_pkg::SIZE_W'((DEPTH < 256) ? DEPTH : 256);

    brbf_pkg::t_state               r_state, n_state;
    logic [brbf_pkg::SIZE_W-1:0]    r_size, n_size;
    logic [brbf_pkg::IDX_W-1:0]     r_widx, n_widx;
    logic [brbf_pkg::IDX_W-1:0]     r_ridx, n_ridx;
    logic [2:0]                     r_func, n_func;
    logic                           r_ok, n_ok;
    logic                           r_get, n_get;
    logic                           r_out_valid, n_out_valid;
    brbf_pkg::t_out_item            r_out, n_out;

    brbf_pkg::t_mod_req             mod_req;
    brbf_pkg::t_mod_rsp             mod_rsp;

    logic                           accept;
    logic                           out_free;
    logic                           mem_we, mem_re;
    logic [7:0]                     mem_rdata;
    logic [brbf_pkg::IDX_W-1:0]     w_next, r_next;
    logic [brbf_pkg::IDX_W-1:0]     cnt, seg, free;

    brbf_mem #(.DEPTH(DEPTH)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (AW'(r_widx)),
        .i_wdata (i_in.data),
        .i_re    (mem_re),
        .i_raddr (AW'(r_ridx)),
        .o_rdata (mem_rdata)
    );

    brbf_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_rsp   (mod_rsp)
    );

    assign accept   = (r_state == brbf_pkg::ST_IDLE) && i_in_valid;
    assign out_free = !r_out_valid || !i_out_stall;

    assign w_next = (brbf_pkg::IDX_W'(r_widx + 1'b1) == r_size) ? '0
                                                                : brbf_pkg::IDX_W'(r_widx + 1'b1);
    assign r_next = (brbf_pkg::IDX_W'(r_ridx + 1'b1) == r_size) ? '0
                                                                : brbf_pkg::IDX_W'(r_ridx + 1'b1);

    assign cnt  = (r_widx >= r_ridx) ? brbf_pkg::IDX_W'(r_widx - r_ridx)
                                     : brbf_pkg::IDX_W'(r_size + r_widx - r_ridx);
    assign seg  = (r_widx >= r_ridx) ? brbf_pkg::IDX_W'(r_widx - r_ridx)
                                     : brbf_pkg::IDX_W'(r_size - r_ridx);
    assign free = brbf_pkg::IDX_W'(r_size - cnt - 1'b1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            brbf_pkg::ST_IDLE: begin
                if (accept) begin
                    if (i_in.func == brbf_pkg::FUNC_ADV_TAIL ||
                        i_in.func == brbf_pkg::FUNC_SET_HEAD) begin
                        n_state = brbf_pkg::ST_MOD;
                    end else begin
                        n_state = brbf_pkg::ST_RESP;
                    end
                end
            end
            brbf_pkg::ST_MOD: begin
                if (mod_rsp.done) begin
                    n_state = brbf_pkg::ST_RESP;
                end
            end
            brbf_pkg::ST_RESP: begin
                if (out_free) begin
                    n_state = brbf_pkg::ST_IDLE;
                end
            end
            default: n_state = brbf_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        o_in_stall  = (r_state != brbf_pkg::ST_IDLE);
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mod_req     = '0;
        n_size      = r_size;
        n_widx      = r_widx;
        n_ridx      = r_ridx;
        n_func      = r_func;
        n_ok        = r_ok;
        n_get       = r_get;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        case (r_state)
            brbf_pkg::ST_IDLE: begin
                if (accept) begin
                    n_func = i_in.func;
                    n_ok   = 1'b0;
                    n_get  = 1'b0;
                    case (i_in.func)
                        brbf_pkg::FUNC_PUT: begin
                            if (w_next != r_ridx) begin
                                mem_we = 1'b1;
                                n_widx = w_next;
                                n_ok   = 1'b1;
                            end
                        end
                        brbf_pkg::FUNC_GET: begin
                            if (r_widx != r_ridx) begin
                                mem_re = 1'b1;
                                n_ridx = r_next;
                                n_ok   = 1'b1;
                                n_get  = 1'b1;
                            end
                        end
                        brbf_pkg::FUNC_FLUSH: begin
                            n_ridx = r_widx;
                        end
                        brbf_pkg::FUNC_ADV_TAIL: begin
                            mod_req.start    = 1'b1;
                            mod_req.dividend = brbf_pkg::DIV_W'(r_ridx) +
                                               brbf_pkg::DIV_W'(i_in.amount);
                            mod_req.divisor  = r_size;
                        end
                        brbf_pkg::FUNC_SET_HEAD: begin
                            mod_req.start    = 1'b1;
                            mod_req.dividend = brbf_pkg::DIV_W'(i_in.amount);
                            mod_req.divisor  = r_size;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            brbf_pkg::ST_MOD: begin
                if (mod_rsp.done) begin
                    if (r_func == brbf_pkg::FUNC_ADV_TAIL) begin
                        n_ridx = mod_rsp.rem;
                    end else begin
                        n_widx = mod_rsp.rem;
                    end
                end
            end
            brbf_pkg::ST_RESP: begin
                if (out_free) begin
                    n_out_valid        = 1'b1;
                    n_out.ok           = r_ok;
                    n_out.read_data    = r_get ? mem_rdata : 8'd0;
                    n_out.fill_count   = cnt[7:0];
                    n_out.free_slots   = free[7:0];
                    n_out.not_empty    = (r_widx != r_ridx);
                    n_out.count_to_end = seg[7:0];
                    n_out.tail_index   = r_ridx[7:0];
                end
            end
            default: begin
            end
        endcase

        if (i_cfg_we) begin
            if (i_cfg_wdata < brbf_pkg::SIZE_W'(2)) begin
                n_size = brbf_pkg::SIZE_W'(2);
            end else if (int'(i_cfg_wdata) > DEPTH) begin
                n_size = brbf_pkg::SIZE_W'(DEPTH);
            end else begin
                n_size = i_cfg_wdata;
            end
            n_widx = '0;
            n_ridx = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= brbf_pkg::ST_IDLE;
            r_size      <= SizeRst;
            r_widx      <= '0;
            r_ridx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_size      <= n_size;
            r_widx      <= n_widx;
            r_ridx      <= n_ridx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func <= n_func;
        r_ok   <= n_ok;
        r_get  <= n_get;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_size_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_size >= brbf_pkg::SIZE_W'(2))
        else $error("size below two");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_widx < r_size) && (r_ridx < r_size))
        else $error("index beyond size");

    a_mod_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_rsp.done |-> (r_state == brbf_pkg::ST_MOD))
        else $error("remainder done outside modulo state");

    a_rd_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.read_data != 8'd0)) |-> o_out.ok)
        else $error("read data without successful get");

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
    localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
    localparam int         IDLE_LIMIT    = 2000;
    localparam int         SETTLE_CYCLES = 16;

    class fifo_scoreboard;
        logic [7:0]          store [256];
        bit                  written [256];
        int unsigned         slots;
        int unsigned         head;
        int unsigned         tail;
        brbf_pkg::t_out_item pending_q [$];
        int                  errors;
        int                  checked;
        int                  noted;

        function new();
            slots = 256;
            head = 0;
            tail = 0;
            errors = 0;
            checked = 0;
            noted = 0;
            foreach (written[i]) written[i] = 1'b0;
        endfunction

        function void resize(logic [brbf_pkg::SIZE_W-1:0] v);
            slots = (v < 2) ? 2 : ((v > 256) ? 256 : v);
            head = 0;
            tail = 0;
        endfunction

        // a get must never land on a slot that was never written
        function bit get_safe();
            return (head == tail) || written[tail];
        endfunction

        function void flag_mismatch(string field, int got, int want);
            $display("transaction %0d: %s got %0h expected %0h", checked, field, got, want);
            errors++;
        endfunction

        function void note_input(brbf_pkg::t_in_item it);
            brbf_pkg::t_out_item r;
            int unsigned         nxt;
            int unsigned         lvl;
            r = '0;
            case (it.func)
                brbf_pkg::FUNC_PUT: begin
                    nxt = (head + 1 == slots) ? 0 : head + 1;
                    if (nxt != tail) begin
                        store[head] = it.data;
                        written[head] = 1'b1;
                        head = nxt;
                        r.ok = 1'b1;
                    end
                end
                brbf_pkg::FUNC_GET: begin
                    if (head != tail) begin
                        r.read_data = store[tail];
                        tail = (tail + 1 == slots) ? 0 : tail + 1;
                        r.ok = 1'b1;
                    end
                end
                brbf_pkg::FUNC_FLUSH:    tail = head;
                brbf_pkg::FUNC_ADV_TAIL: tail = (tail + it.amount) % slots;
                brbf_pkg::FUNC_SET_HEAD: head = it.amount % slots;
                default: ;
            endcase
            lvl = (head >= tail) ? head - tail : slots + head - tail;
            r.fill_count   = 8'(lvl);
            r.free_slots   = 8'(slots - lvl - 1);
            r.not_empty    = (head != tail);
            r.count_to_end = 8'((head >= tail) ? head - tail : slots - tail);
            r.tail_index   = 8'(tail);
            pending_q.push_back(r);
            noted++;
        endfunction

        function void check_result(brbf_pkg::t_out_item got);
            brbf_pkg::t_out_item want;
            if (pending_q.size() == 0) begin
                flag_mismatch("unexpected result", int'(got.tail_index), 0);
                return;
            end
            want = pending_q.pop_front();
            if (got.ok !== want.ok) flag_mismatch("ok", int'(got.ok), int'(want.ok));
            if (got.read_data !== want.read_data)
                flag_mismatch("read_data", int'(got.read_data), int'(want.read_data));
            if (got.fill_count !== want.fill_count)
                flag_mismatch("fill_count", int'(got.fill_count), int'(want.fill_count));
            if (got.free_slots !== want.free_slots)
                flag_mismatch("free_slots", int'(got.free_slots), int'(want.free_slots));
            if (got.not_empty !== want.not_empty)
                flag_mismatch("not_empty", int'(got.not_empty), int'(want.not_empty));
            if (got.count_to_end !== want.count_to_end)
                flag_mismatch("count_to_end", int'(got.count_to_end),
                              int'(want.count_to_end));
            if (got.tail_index !== want.tail_index)
                flag_mismatch("tail_index", int'(got.tail_index), int'(want.tail_index));
            checked++;
        endfunction
    endclass

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        o_in_stall;
    brbf_pkg::t_in_item          in_item = '0;
    logic                        o_out_valid;
    logic                        out_stall = 1'b0;
    brbf_pkg::t_out_item         o_out;
    logic                        cfg_we = 1'b0;
    logic [brbf_pkg::SIZE_W-1:0] cfg_wdata = '0;

    fifo_scoreboard sb;
    bit             calm = 1'b0;
    int             stall_left = 0;
    int             idle_cycles = 0;
    int             size_writes = 0;

    byte_ring_buffer_fifo_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out       (o_out),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    function automatic int burst_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    function automatic int gap_len();
        if (calm || $urandom_range(0, 1) == 0) return 0;
        return burst_len();
    endfunction

    // result side: check, stall pattern, watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !out_stall) sb.check_result(o_out);
        if ((in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (stall_left > 0)
            stall_left--;
        else if (!calm && $urandom_range(0, 3) == 0)
            stall_left = burst_len();
        out_stall <= (stall_left > 0);
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send(input brbf_pkg::t_in_item it);
        int gap;
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_input(it);
        gap = gap_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic issue(input logic [2:0] func, input logic [7:0] data,
                         input logic [7:0] amount);
        brbf_pkg::t_in_item it;
        it.func = func;
        it.data = data;
        it.amount = amount;
        send(it);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [brbf_pkg::SIZE_W-1:0] v);
        settle();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        sb.resize(v);
        size_writes++;
    endtask

    // bursts lean toward filling or draining so full and empty both get hit
    task automatic random_phase(input int n);
        brbf_pkg::t_in_item it;
        int                 put_pct;
        int                 burst;
        int                 r;
        burst = 0;
        put_pct = 50;
        repeat (n) begin
            if (burst == 0) begin
                burst = $urandom_range(5, 40);
                r = $urandom_range(0, 2);
                put_pct = (r == 0) ? 80 : ((r == 1) ? 45 : 15);
            end
            burst--;
            it.data = 8'($urandom_range(0, 255));
            it.amount = 8'($urandom_range(0, 255));
            r = $urandom_range(0, 99);
            if (r < put_pct) begin
                it.func = brbf_pkg::FUNC_PUT;
            end else if (r < 90) begin
                it.func = brbf_pkg::FUNC_GET;
            end else begin
                case ($urandom_range(0, 3))
                    0: it.func = brbf_pkg::FUNC_FLUSH;
                    1: it.func = brbf_pkg::FUNC_ADV_TAIL;
                    2: it.func = brbf_pkg::FUNC_SET_HEAD;
                    default: it.func = 3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
                endcase
            end
            if (it.func == brbf_pkg::FUNC_GET && !sb.get_safe())
                it.func = ($urandom_range(0, 2) == 0) ? brbf_pkg::FUNC_FLUSH
                                                      : brbf_pkg::FUNC_PUT;
            send(it);
            if ($urandom_range(0, 99) == 0) settle();
        end
    endtask

    initial begin
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset size, edge data, status-only codes, drain past data, head moves
        issue(brbf_pkg::FUNC_GET, 8'h00, 8'h00);
        issue(brbf_pkg::FUNC_PUT, 8'h00, 8'h00);
        issue(brbf_pkg::FUNC_PUT, 8'hff, 8'hff);
        issue(brbf_pkg::FUNC_PUT, 8'ha5, 8'h5a);
        issue(brbf_pkg::FUNC_GET, 8'hff, 8'hff);
        issue(brbf_pkg::FUNC_GET, 8'h00, 8'h00);
        issue(FUNC_SPARE_LO, 8'hff, 8'hff);
        issue(FUNC_SPARE_LO + 3'd1, 8'h00, 8'h00);
        issue(FUNC_SPARE_HI, 8'h5a, 8'ha5);
        issue(brbf_pkg::FUNC_FLUSH, 8'h00, 8'h00);
        issue(brbf_pkg::FUNC_PUT, 8'h5a, 8'h00);
        issue(brbf_pkg::FUNC_ADV_TAIL, 8'h00, 8'h00);
        issue(brbf_pkg::FUNC_ADV_TAIL, 8'h00, 8'hff);
        issue(brbf_pkg::FUNC_GET, 8'h00, 8'h00);
        issue(brbf_pkg::FUNC_GET, 8'h00, 8'h00);
        issue(brbf_pkg::FUNC_SET_HEAD, 8'h00, 8'hff);
        issue(brbf_pkg::FUNC_SET_HEAD, 8'h00, 8'h00);
        issue(brbf_pkg::FUNC_FLUSH, 8'h00, 8'h00);

        // size below range clamps to two slots
        write_size('0);
        issue(brbf_pkg::FUNC_PUT, 8'h11, 8'h00);
        issue(brbf_pkg::FUNC_PUT, 8'h22, 8'h00);
        issue(brbf_pkg::FUNC_GET, 8'h00, 8'h00);
        issue(brbf_pkg::FUNC_GET, 8'h00, 8'h00);
        issue(brbf_pkg::FUNC_SET_HEAD, 8'h00, 8'hff);
        issue(brbf_pkg::FUNC_ADV_TAIL, 8'h00, 8'hff);
        issue(brbf_pkg::FUNC_GET, 8'h00, 8'h00);

        // size above range clamps to full depth: fill past full, drain past empty
        write_size('1);
        repeat (256) issue(brbf_pkg::FUNC_PUT, 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)));
        repeat (256) issue(brbf_pkg::FUNC_GET, 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)));

        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: write_size(9'd2);
                1: write_size(9'd1);
                2: write_size(9'd3);
                3: write_size(9'd255);
                4: write_size(9'd256);
                9: write_size(9'($urandom_range(2, 300)));
                default: write_size(9'($urandom_range(4, 20)));
            endcase
            calm = ($urandom_range(0, 3) == 0);
            random_phase(80);
        end
        calm = 1'b0;

        settle();
        if (sb.pending_q.size() != 0)
            sb.flag_mismatch("results never returned", 0, sb.pending_q.size());
        $display("checked %0d results from %0d transactions over %0d size settings",
                 sb.checked, sb.noted, size_writes + 1);
        $display("%0d mismatches", sb.errors);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
